// ===== rtl/tpmb_pkg.sv =====
// Package for the tagged packet match buffer: field widths, result kind codes,
// the scan control bundle and the byte mask helper.
// No dependencies.
package tpmb_pkg;

  localparam int SRC_W   = 8;
  localparam int TAG_W   = 16;
  localparam int BYTES_W = 4;
  localparam int WORD_W  = 64;
  localparam int ROOM_W  = 20;
  localparam int KIND_W  = 2;

  localparam logic [KIND_W-1:0] KIND_STORED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OVERFLOW = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DATA     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_PENDING  = 2'd3;

  typedef struct packed {
    logic             start;
    logic             cmp_valid;
    logic             deliver;
    logic             any_src;
    logic             any_tag;
    logic [SRC_W-1:0] want_src;
    logic [TAG_W-1:0] want_tag;
  } scan_ctl_t;

  // Ones in the low n bytes, all ones for n of eight or more.
  function automatic logic [WORD_W-1:0] byte_mask(input logic [BYTES_W-1:0] n);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int b = 0; b < WORD_W / 8; b++) begin
      m[8*b +: 8] = (BYTES_W'(b) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== rtl/tpmb_if.sv =====
// Valid/ready channel interfaces of the tagged packet match buffer: the
// request channel and the result channel. Depends on tpmb_pkg.
interface tpmb_req_if import tpmb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [SRC_W-1:0]   src_id;
  logic               any_src;
  logic [TAG_W-1:0]   msg_tag;
  logic               any_tag;
  logic               is_tail;
  logic [BYTES_W-1:0] byte_count;
  logic [WORD_W-1:0]  payload;
  logic [ROOM_W-1:0]  room;

  modport source(output valid, mode, src_id, any_src, msg_tag, any_tag, is_tail,
                 byte_count, payload, room, input ready);
  modport sink(input valid, mode, src_id, any_src, msg_tag, any_tag, is_tail,
               byte_count, payload, room, output ready);
endinterface

interface tpmb_res_if import tpmb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [WORD_W-1:0]  data_out;
  logic [BYTES_W-1:0] bytes_out;
  logic [SRC_W-1:0]   from_src;
  logic               end_of_message;
  logic               last;

  modport source(output valid, kind, data_out, bytes_out, from_src, end_of_message,
                 last, input ready);
  modport sink(input valid, kind, data_out, bytes_out, from_src, end_of_message,
               last, output ready);
endinterface

// ===== rtl/tpmb_slot_store.sv =====
// Slot store: one-write, one-read packet memory with registered read data,
// plus the occupancy flags that reset clears. Depends on tpmb_pkg.
module tpmb_slot_store import tpmb_pkg::*; #(
  parameter int NUM_SLOTS    = 16,
  parameter int PACKET_BYTES = 8,
  parameter int ORDER_BITS   = 32,
  localparam int SLOT_W      = $clog2(NUM_SLOTS),
  localparam int DATA_W      = 8 * PACKET_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr_en,
  input  logic [SLOT_W-1:0]     wr_idx,
  input  logic [SRC_W-1:0]      wr_src,
  input  logic [TAG_W-1:0]      wr_tag,
  input  logic [ORDER_BITS-1:0] wr_order,
  input  logic [BYTES_W-1:0]    wr_bytes,
  input  logic [DATA_W-1:0]     wr_data,
  input  logic                  wr_tail,
  input  logic                  free_en,
  input  logic [SLOT_W-1:0]     free_idx,
  input  logic [SLOT_W-1:0]     rd_idx,
  output logic [SLOT_W-1:0]     rd_slot,
  output logic                  rd_occ,
  output logic [SRC_W-1:0]      rd_src,
  output logic [TAG_W-1:0]      rd_tag,
  output logic [ORDER_BITS-1:0] rd_order,
  output logic [BYTES_W-1:0]    rd_bytes,
  output logic [DATA_W-1:0]     rd_data,
  output logic                  rd_tail,
  output logic [NUM_SLOTS-1:0]  occ
);

  localparam int ENTRY_W = SRC_W + TAG_W + ORDER_BITS + BYTES_W + DATA_W + 1;

  logic [ENTRY_W-1:0] mem [NUM_SLOTS];
  logic [ENTRY_W-1:0] rd_entry;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= {wr_src, wr_tag, wr_order, wr_bytes, wr_data, wr_tail};
    end
  end

  always_ff @(posedge clk) begin
    rd_entry <= mem[rd_idx];
    rd_slot  <= rd_idx;
    rd_occ   <= occ[rd_idx];
  end

  assign {rd_src, rd_tag, rd_order, rd_bytes, rd_data, rd_tail} = rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      if (wr_en) begin
        occ[wr_idx] <= 1'b1;
      end
      if (free_en) begin
        occ[free_idx] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/tpmb_oldest_finder.sv =====
// Shared compare unit: looks at one slot per cycle and keeps the oldest
// matching slot (receive) or the first free slot (deliver). Depends on tpmb_pkg.
module tpmb_oldest_finder import tpmb_pkg::*; #(
  parameter int NUM_SLOTS    = 16,
  parameter int PACKET_BYTES = 8,
  parameter int ORDER_BITS   = 32,
  localparam int SLOT_W      = $clog2(NUM_SLOTS),
  localparam int DATA_W      = 8 * PACKET_BYTES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  scan_ctl_t             ctl,
  input  logic [SLOT_W-1:0]     rd_slot,
  input  logic                  rd_occ,
  input  logic [SRC_W-1:0]      rd_src,
  input  logic [TAG_W-1:0]      rd_tag,
  input  logic [ORDER_BITS-1:0] rd_order,
  input  logic [BYTES_W-1:0]    rd_bytes,
  input  logic [DATA_W-1:0]     rd_data,
  input  logic                  rd_tail,
  output logic                  found,
  output logic [SLOT_W-1:0]     best_slot,
  output logic [SRC_W-1:0]      best_src,
  output logic [BYTES_W-1:0]    best_bytes,
  output logic [DATA_W-1:0]     best_data,
  output logic                  best_tail
);

  logic [ORDER_BITS-1:0] best_order;
  logic                  match;
  logic                  older;
  logic                  take;

  assign match = rd_occ && (ctl.any_src || rd_src == ctl.want_src)
                        && (ctl.any_tag || rd_tag == ctl.want_tag);
  // Strict compare: on equal stamps the lower slot, seen first, stays.
  assign older = rd_order < best_order;
  assign take  = ctl.cmp_valid && (ctl.deliver ? (!rd_occ && !found)
                                               : (match && (!found || older)));

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.start) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_slot  <= rd_slot;
      best_order <= rd_order;
      best_src   <= rd_src;
      best_bytes <= rd_bytes;
      best_data  <= rd_data;
      best_tail  <= rd_tail;
    end
  end

endmodule

// ===== rtl/tagged_packet_match_buffer_core.sv =====
// Tagged packet match buffer: a slot store of arriving packets with receives
// matched on sender and tag (either may be a wildcard).
// Channels: req (valid/ready, sink) carries one request; res (valid/ready,
// source) carries results. A request is taken when req.valid and req.ready are
// high at a clock edge. req.ready is high only while no request is in work.
// A deliver request (mode 0) stamps the packet with the next arrival number,
// stores it in the lowest free slot and returns one result: stored, or
// overflow when every slot is taken. A receive request (mode 1) returns one
// data result per packet taken, oldest match first, cut to the room left, and
// stops after a tail packet or with a pending result; last marks the final one.
// Search: each search reads every slot through one memory port, one slot a
// cycle, into a single compare unit. A deliver runs one search before its
// result; a receive runs one search per packet taken, plus one more that ends
// pending unless it ends at a tail. The next request can be taken in the cycle
// after the final result is loaded.
// One output register holds a result; a new request is accepted while it
// waits. When res stalls, the block holds before loading the next result.
// Reset (rst, synchronous) frees every slot and clears the arrival number.
module tagged_packet_match_buffer_core import tpmb_pkg::*; #(
  parameter int NUM_SLOTS    = 16,
  parameter int PACKET_BYTES = 8,
  parameter int ORDER_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst,
  tpmb_req_if.sink    req,
  tpmb_res_if.source  res
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
  localparam int DATA_W = 8 * PACKET_BYTES;
  localparam logic [BYTES_W-1:0] BYTES_CAP = BYTES_W'(PACKET_BYTES);
  localparam logic [CNT_W-1:0]   SCAN_END  = CNT_W'(NUM_SLOTS);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DECIDE = 2'd2;

  logic [1:0]            state;
  logic [CNT_W-1:0]      cnt;
  logic                  op_deliver;
  logic [SRC_W-1:0]      op_src;
  logic                  op_any_src;
  logic [TAG_W-1:0]      op_tag;
  logic                  op_any_tag;
  logic                  op_tail;
  logic [BYTES_W-1:0]    op_bytes;
  logic [DATA_W-1:0]     op_data;
  logic [ROOM_W-1:0]     left;
  logic [ORDER_BITS-1:0] arrival;

  logic                  out_valid;
  logic [KIND_W-1:0]     out_kind;
  logic [WORD_W-1:0]     out_data;
  logic [BYTES_W-1:0]    out_bytes;
  logic [SRC_W-1:0]      out_src;
  logic                  out_eom;
  logic                  out_last;

  logic                  accept;
  logic                  out_free;
  logic                  decide;
  logic                  emit_data;
  logic                  more;
  logic                  store_wr;
  logic [BYTES_W-1:0]    size;
  logic [SLOT_W-1:0]     rd_idx;
  scan_ctl_t             ctl;

  logic [KIND_W-1:0]     load_kind;
  logic [WORD_W-1:0]     load_data;
  logic [BYTES_W-1:0]    load_bytes;
  logic [SRC_W-1:0]      load_src;
  logic                  load_eom;
  logic                  load_last;

  logic [SLOT_W-1:0]     rd_slot;
  logic                  rd_occ;
  logic [SRC_W-1:0]      rd_src;
  logic [TAG_W-1:0]      rd_tag;
  logic [ORDER_BITS-1:0] rd_order;
  logic [BYTES_W-1:0]    rd_bytes;
  logic [DATA_W-1:0]     rd_data;
  logic                  rd_tail;
  logic [NUM_SLOTS-1:0]  occ;

  logic                  found;
  logic [SLOT_W-1:0]     best_slot;
  logic [SRC_W-1:0]      best_src;
  logic [BYTES_W-1:0]    best_bytes;
  logic [DATA_W-1:0]     best_data;
  logic                  best_tail;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || res.ready;
  assign decide    = (state == S_DECIDE) && out_free;
  assign emit_data = decide && !op_deliver && found;
  assign more      = emit_data && !best_tail;
  assign store_wr  = decide && op_deliver && found;

  assign size   = (ROOM_W'(best_bytes) < left) ? best_bytes : left[BYTES_W-1:0];
  assign rd_idx = (cnt < SCAN_END) ? cnt[SLOT_W-1:0] : '0;

  always_comb begin
    ctl.start     = accept || more;
    ctl.cmp_valid = (state == S_SCAN) && (cnt != '0);
    ctl.deliver   = op_deliver;
    ctl.any_src   = op_any_src;
    ctl.any_tag   = op_any_tag;
    ctl.want_src  = op_src;
    ctl.want_tag  = op_tag;
  end

  always_comb begin
    load_data  = '0;
    load_bytes = '0;
    load_src   = '0;
    load_eom   = 1'b0;
    load_last  = 1'b1;
    if (op_deliver) begin
      load_kind = found ? KIND_STORED : KIND_OVERFLOW;
    end else if (!found) begin
      load_kind = KIND_PENDING;
    end else begin
      load_kind  = KIND_DATA;
      load_data  = WORD_W'(best_data) & byte_mask(size);
      load_bytes = size;
      load_src   = best_src;
      load_eom   = best_tail;
      load_last  = best_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      arrival <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
            cnt   <= '0;
            if (!req.mode) begin
              arrival <= arrival + 1'b1;
            end
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == SCAN_END) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (decide) begin
            // Rescan after a body packet; anything else ends the request.
            state <= more ? S_SCAN : S_IDLE;
            cnt   <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_deliver <= !req.mode;
      op_src     <= req.src_id;
      op_any_src <= req.any_src;
      op_tag     <= req.msg_tag;
      op_any_tag <= req.any_tag;
      op_tail    <= req.is_tail;
      op_bytes   <= (req.byte_count > BYTES_CAP) ? BYTES_CAP : req.byte_count;
      op_data    <= req.payload[DATA_W-1:0];
      left       <= req.room;
    end else if (emit_data) begin
      left <= left - ROOM_W'(size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (decide) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      out_kind  <= load_kind;
      out_data  <= load_data;
      out_bytes <= load_bytes;
      out_src   <= load_src;
      out_eom   <= load_eom;
      out_last  <= load_last;
    end
  end

  assign res.valid          = out_valid;
  assign res.kind           = out_kind;
  assign res.data_out       = out_data;
  assign res.bytes_out      = out_bytes;
  assign res.from_src       = out_src;
  assign res.end_of_message = out_eom;
  assign res.last           = out_last;

  tpmb_slot_store #(
    .NUM_SLOTS    (NUM_SLOTS),
    .PACKET_BYTES (PACKET_BYTES),
    .ORDER_BITS   (ORDER_BITS)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (store_wr),
    .wr_idx   (best_slot),
    .wr_src   (op_src),
    .wr_tag   (op_tag),
    .wr_order (arrival),
    .wr_bytes (op_bytes),
    .wr_data  (op_data),
    .wr_tail  (op_tail),
    .free_en  (emit_data),
    .free_idx (best_slot),
    .rd_idx   (rd_idx),
    .rd_slot  (rd_slot),
    .rd_occ   (rd_occ),
    .rd_src   (rd_src),
    .rd_tag   (rd_tag),
    .rd_order (rd_order),
    .rd_bytes (rd_bytes),
    .rd_data  (rd_data),
    .rd_tail  (rd_tail),
    .occ      (occ)
  );

  tpmb_oldest_finder #(
    .NUM_SLOTS    (NUM_SLOTS),
    .PACKET_BYTES (PACKET_BYTES),
    .ORDER_BITS   (ORDER_BITS)
  ) u_finder (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rd_slot    (rd_slot),
    .rd_occ     (rd_occ),
    .rd_src     (rd_src),
    .rd_tag     (rd_tag),
    .rd_order   (rd_order),
    .rd_bytes   (rd_bytes),
    .rd_data    (rd_data),
    .rd_tail    (rd_tail),
    .found      (found),
    .best_slot  (best_slot),
    .best_src   (best_src),
    .best_bytes (best_bytes),
    .best_data  (best_data),
    .best_tail  (best_tail)
  );

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    decide && load_last |=> state == S_IDLE)
    else $error("final result did not return the sequencer to idle");

  a_store_fills: assert property (@(posedge clk) disable iff (rst)
    store_wr |=> $countones(occ) == $past($countones(occ)) + 1)
    else $error("stored packet did not fill a free slot");

  a_take_frees: assert property (@(posedge clk) disable iff (rst)
    emit_data |=> $countones(occ) + 1 == $past($countones(occ)))
    else $error("taken packet did not free its slot");

  a_room_kept: assert property (@(posedge clk) disable iff (rst)
    emit_data |-> ROOM_W'(size) <= left)
    else $error("data result exceeds the room left");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("request taken while previous one still in work");

endmodule

// ===== verif/tb_tagged_packet_match_buffer_core.sv =====
`timescale 1ns / 100ps
// Testbench for tagged_packet_match_buffer_core: deliver and receive requests go in,
// results are predicted by a behavioral slot store and checked field by field.
// Depends on tpmb_pkg, tpmb_if and the core RTL.
module tb_tagged_packet_match_buffer_core;
  import tpmb_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int PACKET_BYTES = 8;
  // Narrow arrival stamps: eight bits instead of the core's default 32.
  localparam int ORDER_BITS   = 8;
  localparam int SCAN_CYCLES  = NUM_SLOTS + 2;
  localparam int RANDOM_ITEMS = 244;
  localparam longint CYCLE_LIMIT = 2000000;

  localparam logic MODE_DELIVER = 1'b0;
  localparam logic MODE_RECEIVE = 1'b1;

  typedef enum logic [1:0] {SLOT_FREE, SLOT_BODY, SLOT_TAIL} slot_state_t;

  typedef struct {
    logic               mode;
    logic [SRC_W-1:0]   src_id;
    logic               any_src;
    logic [TAG_W-1:0]   msg_tag;
    logic               any_tag;
    logic               is_tail;
    logic [BYTES_W-1:0] byte_count;
    logic [WORD_W-1:0]  payload;
    logic [ROOM_W-1:0]  room;
    int                 gap;
  } pkt_req_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  data;
    logic [BYTES_W-1:0] bytes;
    logic [SRC_W-1:0]   src;
    logic               eom;
    logic               last;
  } match_res_t;

  logic clk;
  logic rst;

  tpmb_req_if req_ch();
  tpmb_res_if res_ch();

  tagged_packet_match_buffer_core #(
    .NUM_SLOTS(NUM_SLOTS),
    .PACKET_BYTES(PACKET_BYTES),
    .ORDER_BITS(ORDER_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  // Shadow copy of the slot store.
  slot_state_t           slot_state [NUM_SLOTS];
  logic [SRC_W-1:0]      slot_src   [NUM_SLOTS];
  logic [TAG_W-1:0]      slot_tag   [NUM_SLOTS];
  logic [ORDER_BITS-1:0] slot_stamp [NUM_SLOTS];
  logic [BYTES_W-1:0]    slot_len   [NUM_SLOTS];
  logic [WORD_W-1:0]     slot_word  [NUM_SLOTS];
  logic [ORDER_BITS-1:0] arrival_num;

  pkt_req_t   request_queue[$];
  match_res_t awaited_results[$];
  pkt_req_t   drive_req;
  pkt_req_t   seen_req;
  match_res_t got_res;
  match_res_t want_res;

  bit     req_fire;
  bit     calm_sender;
  int     gap_left;
  int     stall_left;
  int     total_items;
  int     accepted_items;
  int     error_count;
  int     deliver_count;
  int     receive_count;
  int     result_count;
  int     overflow_count;
  int     pending_count;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [WORD_W-1:0] low_bytes(input int n);
    if (n >= WORD_W / 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ROOM_W-1:0] pick_room();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return ROOM_W'($urandom_range(0, 40));
    if (roll < 90) return ROOM_W'($urandom);
    return ($urandom_range(0, 1) != 0) ? '1 : '0;
  endfunction

  function automatic logic [SRC_W-1:0] pool_src();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'h01;
      2: return 8'h80;
      default: return 8'hFF;
    endcase
  endfunction

  function automatic logic [TAG_W-1:0] pool_tag();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Every field random; callers overwrite the ones that matter for the mode.
  function automatic pkt_req_t any_req();
    pkt_req_t r;
    r.mode       = 1'($urandom);
    r.src_id     = SRC_W'($urandom);
    r.any_src    = 1'($urandom);
    r.msg_tag    = TAG_W'($urandom);
    r.any_tag    = 1'($urandom);
    r.is_tail    = 1'($urandom);
    r.byte_count = BYTES_W'($urandom);
    r.payload    = rand_word();
    r.room       = ROOM_W'($urandom);
    r.gap        = 0;
    return r;
  endfunction

  task automatic queue_req(input pkt_req_t r);
    r.gap = calm_sender ? 0 : pick_gap();
    request_queue.push_back(r);
  endtask

  task automatic add_deliver(input logic [SRC_W-1:0] src, input logic [TAG_W-1:0] tag,
                             input logic tail, input logic [BYTES_W-1:0] cnt,
                             input logic [WORD_W-1:0] word);
    pkt_req_t r;
    r = any_req();
    r.mode       = MODE_DELIVER;
    r.src_id     = src;
    r.msg_tag    = tag;
    r.is_tail    = tail;
    r.byte_count = cnt;
    r.payload    = word;
    queue_req(r);
  endtask

  task automatic add_receive(input logic [SRC_W-1:0] src, input logic any_s,
                             input logic [TAG_W-1:0] tag, input logic any_t,
                             input logic [ROOM_W-1:0] room);
    pkt_req_t r;
    r = any_req();
    r.mode    = MODE_RECEIVE;
    r.src_id  = src;
    r.any_src = any_s;
    r.msg_tag = tag;
    r.any_tag = any_t;
    r.room    = room;
    queue_req(r);
  endtask

  // Work out the results of one accepted request and update the shadow store.
  task automatic predict_match_results(input pkt_req_t r);
    int         slot;
    int         best;
    int         taken;
    int         left;
    int         size;
    bit         done;
    match_res_t outcome;
    if (r.mode == MODE_DELIVER) begin
      arrival_num = arrival_num + 1'b1;
      slot = -1;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
        if (slot_state[i] == SLOT_FREE) slot = i;
      end
      outcome = '0;
      outcome.last = 1'b1;
      if (slot < 0) begin
        outcome.kind = KIND_OVERFLOW;
      end else begin
        outcome.kind     = KIND_STORED;
        slot_state[slot] = r.is_tail ? SLOT_TAIL : SLOT_BODY;
        slot_src[slot]   = r.src_id;
        slot_tag[slot]   = r.msg_tag;
        slot_stamp[slot] = arrival_num;
        slot_len[slot]   = (r.byte_count > PACKET_BYTES) ? BYTES_W'(PACKET_BYTES)
                                                         : r.byte_count;
        slot_word[slot]  = r.payload & low_bytes(PACKET_BYTES);
      end
      awaited_results.push_back(outcome);
    end else begin
      taken = 0;
      done  = 1'b0;
      while (!done) begin
        best = -1;
        // Strict compare keeps the lowest slot on equal stamps.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_state[i] != SLOT_FREE && (r.any_src || slot_src[i] == r.src_id) &&
              (r.any_tag || slot_tag[i] == r.msg_tag) &&
              (best < 0 || slot_stamp[i] < slot_stamp[best]))
            best = i;
        end
        outcome = '0;
        if (best < 0) begin
          outcome.kind = KIND_PENDING;
          outcome.last = 1'b1;
          done = 1'b1;
        end else begin
          left  = (int'(r.room) > taken) ? int'(r.room) - taken : 0;
          size  = (int'(slot_len[best]) < left) ? int'(slot_len[best]) : left;
          taken = taken + size;
          outcome.kind  = KIND_DATA;
          outcome.data  = slot_word[best] & low_bytes(size);
          outcome.bytes = BYTES_W'(size);
          outcome.src   = slot_src[best];
          outcome.eom   = (slot_state[best] == SLOT_TAIL);
          outcome.last  = outcome.eom;
          slot_state[best] = SLOT_FREE;
          done = outcome.eom;
        end
        awaited_results.push_back(outcome);
      end
    end
  endtask

  // Request driver: hold each request until taken, then wait out the next one's gap.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_fire || !req_ch.valid) begin
      if (request_queue.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (gap_left > 0) begin
        req_ch.valid <= 1'b0;
        gap_left = gap_left - 1;
      end else begin
        drive_req = request_queue.pop_front();
        req_ch.mode       <= drive_req.mode;
        req_ch.src_id     <= drive_req.src_id;
        req_ch.any_src    <= drive_req.any_src;
        req_ch.msg_tag    <= drive_req.msg_tag;
        req_ch.any_tag    <= drive_req.any_tag;
        req_ch.is_tail    <= drive_req.is_tail;
        req_ch.byte_count <= drive_req.byte_count;
        req_ch.payload    <= drive_req.payload;
        req_ch.room       <= drive_req.room;
        req_ch.valid      <= 1'b1;
        gap_left = (request_queue.size() > 0) ? request_queue[0].gap : 0;
      end
    end
  end

  // Result back-pressure, with no new stall begun in every third stretch of the run.
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      res_ch.ready <= 1'b1;
      if ((cycle_count / 1500) % 3 != 2 && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_fire <= 1'b0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_state[i] = SLOT_FREE;
      arrival_num = '0;
    end else begin
      req_fire <= req_ch.valid && req_ch.ready;
      if (res_ch.valid && res_ch.ready) begin
        got_res.kind  = res_ch.kind;
        got_res.data  = res_ch.data_out;
        got_res.bytes = res_ch.bytes_out;
        got_res.src   = res_ch.from_src;
        got_res.eom   = res_ch.end_of_message;
        got_res.last  = res_ch.last;
        result_count++;
        if (got_res.kind == KIND_OVERFLOW) overflow_count++;
        if (got_res.kind == KIND_PENDING) pending_count++;
        if (awaited_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("cycle %0d: result with nothing expected: kind %0d data %h bytes %0d",
                     cycle_count, got_res.kind, got_res.data, got_res.bytes);
        end else begin
          want_res = awaited_results.pop_front();
          if (got_res.kind !== want_res.kind || got_res.data !== want_res.data ||
              got_res.bytes !== want_res.bytes || got_res.src !== want_res.src ||
              got_res.eom !== want_res.eom || got_res.last !== want_res.last) begin
            error_count++;
            if (error_count <= 10) begin
              $display("cycle %0d: expected kind %0d data %h bytes %0d src %h eom %b last %b",
                       cycle_count, want_res.kind, want_res.data, want_res.bytes,
                       want_res.src, want_res.eom, want_res.last);
              $display("          got      kind %0d data %h bytes %0d src %h eom %b last %b",
                       got_res.kind, got_res.data, got_res.bytes, got_res.src,
                       got_res.eom, got_res.last);
            end
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        seen_req.mode       = req_ch.mode;
        seen_req.src_id     = req_ch.src_id;
        seen_req.any_src    = req_ch.any_src;
        seen_req.msg_tag    = req_ch.msg_tag;
        seen_req.any_tag    = req_ch.any_tag;
        seen_req.is_tail    = req_ch.is_tail;
        seen_req.byte_count = req_ch.byte_count;
        seen_req.payload    = req_ch.payload;
        seen_req.room       = req_ch.room;
        seen_req.gap        = 0;
        if (seen_req.mode == MODE_DELIVER) deliver_count++;
        else receive_count++;
        accepted_items++;
        predict_match_results(seen_req);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d requests taken",
               cycle_count, accepted_items, total_items);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int directed_items;
    int roll;
    int len;
    logic [SRC_W-1:0] src;
    logic [TAG_W-1:0] tag;
    pkt_req_t r;

    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = MODE_DELIVER;
    req_ch.src_id = '0;
    req_ch.any_src = 1'b0;
    req_ch.msg_tag = '0;
    req_ch.any_tag = 1'b0;
    req_ch.is_tail = 1'b0;
    req_ch.byte_count = '0;
    req_ch.payload = '0;
    req_ch.room = '0;
    res_ch.ready = 1'b0;
    req_fire = 1'b0;
    gap_left = 0;
    stall_left = 0;
    cycle_count = 0;
    accepted_items = 0;
    error_count = 0;
    deliver_count = 0;
    receive_count = 0;
    result_count = 0;
    overflow_count = 0;
    pending_count = 0;
    calm_sender = 1'b0;

    // Directed: empty store, field extremes, room running out, overflow, full drain.
    add_receive(8'h00, 1'b1, 16'h0000, 1'b1, '0);
    add_deliver(8'h00, 16'h0000, 1'b0, 4'd0, '1);
    add_deliver(8'hFF, 16'hFFFF, 1'b1, 4'd15, '1);
    add_deliver(8'h5A, 16'h1234, 1'b0, 4'd8, rand_word());
    add_deliver(8'h5A, 16'h1234, 1'b1, 4'd3, rand_word());
    add_receive(8'h5A, 1'b0, 16'h1234, 1'b0, 20'd5);
    add_receive(8'hFF, 1'b0, 16'h0000, 1'b1, '1);
    add_receive(8'h00, 1'b1, 16'h0000, 1'b0, 20'd1);
    for (int i = 0; i <= NUM_SLOTS; i++)
      add_deliver(SRC_W'(i * 17), TAG_W'(i), 1'b0, BYTES_W'(i % 10), rand_word());
    add_receive(8'h00, 1'b1, 16'h0000, 1'b1, '1);
    directed_items = request_queue.size();

    while (request_queue.size() < directed_items + RANDOM_ITEMS) begin
      calm_sender = ((request_queue.size() / 40) % 4) == 2;
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        // One message: body packets and usually a tail, then usually a matching receive.
        src = pool_src();
        tag = pool_tag();
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          add_deliver(src, tag, (k == len - 1) && ($urandom_range(0, 4) != 0),
                      BYTES_W'($urandom_range(0, 8)), rand_word());
        if ($urandom_range(0, 3) != 0)
          add_receive(src, $urandom_range(0, 5) == 0, tag, $urandom_range(0, 5) == 0,
                      pick_room());
      end else if (roll < 80) begin
        r = any_req();
        r.mode = MODE_DELIVER;
        if ($urandom_range(0, 1) != 0) r.src_id = pool_src();
        queue_req(r);
      end else if (roll < 95) begin
        r = any_req();
        r.mode = MODE_RECEIVE;
        r.any_src = $urandom_range(0, 4) < 3;
        r.any_tag = $urandom_range(0, 4) < 3;
        if ($urandom_range(0, 1) != 0) r.src_id = pool_src();
        if ($urandom_range(0, 1) != 0) r.msg_tag = pool_tag();
        r.room = pick_room();
        queue_req(r);
      end else begin
        // Flush: a few receives that take anything.
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++)
          add_receive(pool_src(), 1'b1, pool_tag(), 1'b1, pick_room());
      end
    end
    total_items = request_queue.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_items < total_items || awaited_results.size() != 0) @(negedge clk);
    repeat (4 * SCAN_CYCLES) @(negedge clk);

    if (awaited_results.size() != 0) begin
      error_count += awaited_results.size();
      $display("%0d expected results never arrived", awaited_results.size());
    end

    $display("Ran %0d deliveries (%0d overflowed) and %0d receives (%0d ended pending),",
             deliver_count, overflow_count, receive_count, pending_count);
    $display("%0d results checked in %0d cycles, %0d errors.",
             result_count, cycle_count, error_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
